// ----- design/ctm_pkg.sv -----
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared constants and types for the compass turn median window block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctm_pkg;

  localparam int SAMPLES_PER_GROUP = 10;
  localparam int IDX_W             = $clog2(SAMPLES_PER_GROUP);
  localparam int CNT_W             = $clog2(SAMPLES_PER_GROUP + 1);
  localparam int MEDIAN_IDX        = (SAMPLES_PER_GROUP - 1) / 2;

  localparam int DEG_W             = 9;
  localparam logic [DEG_W-1:0] FULL_CIRCLE = 9'd360;

  localparam logic [7:0] TOL_RESET   = 8'd10;
  localparam logic [6:0] POWER_RESET = 7'd70;

  // configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_POWER     = 1'b1;

  // input opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DRIVE   = 2'd0;
  localparam logic [1:0] KIND_TURNING = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [DEG_W-1:0] bearing;
    logic [CNT_W-1:0] count;
  } sort_req_t;

  typedef struct packed {
    logic             valid;
    logic             full;
    logic [DEG_W-1:0] median;
  } sort_rsp_t;

endpackage

`default_nettype wire

// ----- design/ctm_ram.sv -----
// ----------------------------------------------------------------------------
// ctm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_ram #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ctm_sorter.sv -----
// ----------------------------------------------------------------------------
// ctm_sorter
// Keeps the current sample group sorted in RAM by insertion: walks down from
// the top entry one read per cycle, shifting larger entries up, then places
// the new sample. On a full group the lower median entry is read out.
// ----------------------------------------------------------------------------
`default_nettype none

module ctm_sorter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctm_pkg::sort_req_t req,
  output ctm_pkg::sort_rsp_t      rsp
);

  import ctm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_PLACE = 5'b00100,
    S_MRD   = 5'b01000,
    S_MWT   = 5'b10000
  } sort_state_t;

  sort_state_t      state;
  logic [IDX_W-1:0] k;
  logic [DEG_W-1:0] v;
  logic             full;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DEG_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [DEG_W-1:0] rd_data;
  logic             shift_up;

  assign shift_up = rd_data > v;

  ctm_ram #(
    .DEPTH(SAMPLES_PER_GROUP),
    .WIDTH(DEG_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k;
    wr_data = v;
    rd_en   = 1'b0;
    rd_addr = k - IDX_W'(1);
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.count == '0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = req.bearing;
          end else begin
            rd_en   = 1'b1;
            rd_addr = req.count[IDX_W-1:0] - IDX_W'(1);
          end
        end
      end
      S_WALK: begin
        wr_en = 1'b1;
        if (shift_up) begin
          wr_data = rd_data;
          if (k != IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = k - IDX_W'(2);
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_MRD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(MEDIAN_IDX);
      end
      S_MWT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            v    <= req.bearing;
            k    <= req.count[IDX_W-1:0];
            full <= req.count == CNT_W'(SAMPLES_PER_GROUP - 1);
            if (req.count == '0) begin
              rsp.valid <= 1'b1;
              rsp.full  <= 1'b0;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (shift_up) begin
            k <= k - IDX_W'(1);
            if (k == IDX_W'(1)) begin
              state <= S_PLACE;
            end
          end else if (full) begin
            state <= S_MRD;
          end else begin
            rsp.valid <= 1'b1;
            rsp.full  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_PLACE: begin
          if (full) begin
            state <= S_MRD;
          end else begin
            rsp.valid <= 1'b1;
            rsp.full  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_MRD: begin
          state <= S_MWT;
        end
        S_MWT: begin
          rsp.valid  <= 1'b1;
          rsp.full   <= 1'b1;
          rsp.median <= rd_data;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (k != '0))
    else $error("insertion walk below entry zero");

  a_median_read: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.full) |-> ($past(state) == S_MWT))
    else $error("median reported without median read");

endmodule

`default_nettype wire

// ----- design/compass_turn_median_window_top.sv -----
// ----------------------------------------------------------------------------
// compass_turn_median_window_top
// Compass-guided turn controller with median-filtered headings.
// ----------------------------------------------------------------------------
// A start transaction does not occupy the block. A bearing sample is inserted
// in sorted order into the group RAM: the insertion walks from the top entry
// down, one RAM read per cycle, and the tenth sample of a group adds a read
// of the median entry. A new transaction is taken once the insertion is
// finished and the result register is free or being emptied.
`default_nettype none

module compass_turn_median_window_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       opcode,
  input  wire logic signed [9:0]          turn_degrees,
  input  wire logic [ctm_pkg::DEG_W-1:0]  bearing,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      result_kind,
  output logic                            turn_positive,
  output logic [6:0]                      power,
  output logic [ctm_pkg::DEG_W-1:0]       median_bearing,
  output logic [ctm_pkg::DEG_W-1:0]       target_heading,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [7:0]                 cfg_data
);

  import ctm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FIRST = 3'b010,
    PH_TURN  = 3'b100
  } phase_t;

  phase_t             phase;
  logic               busy;
  logic [CNT_W-1:0]   sample_count;
  logic signed [9:0]  pending_angle;
  logic [DEG_W-1:0]   target;
  logic [7:0]         window_tolerance;
  logic [6:0]         drive_power;

  logic               in_fire;
  logic [DEG_W-1:0]   bearing_wrapped;
  logic               angle_positive;
  sort_req_t          sreq;
  sort_rsp_t          srsp;

  logic signed [10:0] tgt_sum;
  logic signed [10:0] tgt_wrapped;
  logic [DEG_W-1:0]   tgt_new;
  logic [DEG_W-1:0]   diff;
  logic [DEG_W-1:0]   diff_alt;
  logic [DEG_W-1:0]   arc;
  logic               in_window;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign bearing_wrapped = (bearing >= FULL_CIRCLE) ? bearing - FULL_CIRCLE : bearing;
  assign angle_positive  = !pending_angle[9] && (pending_angle != '0);

  assign sreq.valid   = in_fire && (opcode == OP_SAMPLE) && (phase != PH_IDLE);
  assign sreq.bearing = bearing_wrapped;
  assign sreq.count   = sample_count;

  ctm_sorter u_sorter (
    .clk(clk),
    .rst(rst),
    .req(sreq),
    .rsp(srsp)
  );

  // target = (median + angle) mod 360; the sum spans -512..870
  always_comb begin
    tgt_sum = $signed({2'b00, srsp.median}) + 11'(pending_angle);
    if (tgt_sum < -11'sd360) begin
      tgt_wrapped = tgt_sum + 11'sd720;
    end else if (tgt_sum < 0) begin
      tgt_wrapped = tgt_sum + 11'sd360;
    end else if (tgt_sum >= 11'sd720) begin
      tgt_wrapped = tgt_sum - 11'sd720;
    end else if (tgt_sum >= 11'sd360) begin
      tgt_wrapped = tgt_sum - 11'sd360;
    end else begin
      tgt_wrapped = tgt_sum;
    end
    tgt_new = tgt_wrapped[DEG_W-1:0];
  end

  // circular distance from target to median
  assign diff      = (srsp.median > target) ? srsp.median - target : target - srsp.median;
  assign diff_alt  = FULL_CIRCLE - diff;
  assign arc       = (diff > diff_alt) ? diff_alt : diff;
  assign in_window = arc < {1'b0, window_tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_tolerance <= TOL_RESET;
      drive_power      <= POWER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TOLERANCE: window_tolerance <= cfg_data;
        CFG_POWER:     drive_power      <= cfg_data[6:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      busy          <= 1'b0;
      sample_count  <= '0;
      pending_angle <= '0;
      target        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        if (opcode == OP_START) begin
          sample_count  <= '0;
          pending_angle <= turn_degrees;
          if (turn_degrees == '0) begin
            phase          <= PH_IDLE;
            out_valid      <= 1'b1;
            result_kind    <= KIND_DONE;
            turn_positive  <= 1'b0;
            power          <= '0;
            median_bearing <= '0;
            target_heading <= '0;
          end else begin
            phase <= PH_FIRST;
          end
        end else if (phase != PH_IDLE) begin
          busy <= 1'b1;
        end
      end
      if (srsp.valid) begin
        busy <= 1'b0;
        if (!srsp.full) begin
          sample_count <= sample_count + CNT_W'(1);
        end else begin
          sample_count   <= '0;
          out_valid      <= 1'b1;
          turn_positive  <= angle_positive;
          median_bearing <= srsp.median;
          if (phase == PH_FIRST) begin
            target         <= tgt_new;
            phase          <= PH_TURN;
            result_kind    <= KIND_DRIVE;
            power          <= drive_power;
            target_heading <= tgt_new;
          end else begin
            power          <= '0;
            target_heading <= target;
            if (in_window) begin
              phase       <= PH_IDLE;
              result_kind <= KIND_DONE;
            end else begin
              result_kind <= KIND_TURNING;
            end
          end
        end
      end
    end
  end

  a_rsp_while_busy: assert property (@(posedge clk) disable iff (rst)
    srsp.valid |-> busy)
    else $error("sorter response without pending insertion");

  a_group_needs_turn: assert property (@(posedge clk) disable iff (rst)
    (srsp.valid && srsp.full) |-> (phase != PH_IDLE))
    else $error("group completed while idle");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    (srsp.valid && srsp.full) |-> !out_valid)
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compass turn median window block.
// ----------------------------------------------------------------------------
// Start and bearing transactions go in over a valid/ready port. A built-in
// turn predictor works out the report that each accepted transaction causes
// and queues it. A checker compares every report the block gives out, field
// by field, against the oldest queued one. A short directed list covers the
// special cases. Random turns follow: a start, then groups of noisy bearings
// that close in on the target, mixed with abandoned turns, zero starts, stray
// samples and out-of-range bearings. Both sides idle at random, the receiver
// also holds off for a long stretch, and the window tolerance and drive power
// are changed between tests, extremes included.
// ----------------------------------------------------------------------------
module tb;
  import ctm_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED   = 40;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {TURN_IDLE, TURN_AWAIT_FIRST, TURN_ACTIVE} turn_phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             positive;
    logic [6:0]       power;
    logic [DEG_W-1:0] median;
    logic [DEG_W-1:0] target;
  } turn_report_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    opcode;
  logic signed [9:0]       turn_degrees;
  logic [DEG_W-1:0]        bearing;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              result_kind;
  logic                    turn_positive;
  logic [6:0]              power;
  logic [DEG_W-1:0]        median_bearing;
  logic [DEG_W-1:0]        target_heading;
  logic                    cfg_wr_en;
  logic                    cfg_index;
  logic [7:0]              cfg_data;

  turn_report_t            expected_reports[$];

  turn_phase_t             pred_phase     = TURN_IDLE;
  int                      pred_count     = 0;
  logic [DEG_W-1:0]        pred_group [SAMPLES_PER_GROUP];
  int                      pred_angle     = 0;
  logic [DEG_W-1:0]        pred_target    = '0;
  logic [7:0]              pred_tolerance = TOL_RESET;
  logic [6:0]              pred_power     = POWER_RESET;

  int send_idle_pct  = 25;
  int recv_idle_pct  = 74;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int ignored_count  = 0;
  int drive_count    = 0;
  int turning_count  = 0;
  int done_count     = 0;

  compass_turn_median_window_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .turn_degrees   (turn_degrees),
    .bearing        (bearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .turn_positive  (turn_positive),
    .power          (power),
    .median_bearing (median_bearing),
    .target_heading (target_heading),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int wrap_degrees(int v);
    int r;
    r = v % 360;
    if (r < 0) r += 360;
    return r;
  endfunction

  // lower median: the entry with at most MEDIAN_IDX values strictly below it
  // and more than MEDIAN_IDX values at or below it
  function automatic logic [DEG_W-1:0] group_lower_median();
    int below;
    int not_above;
    int i;
    int j;
    logic [DEG_W-1:0] pick;
    pick = pred_group[0];
    for (i = 0; i < SAMPLES_PER_GROUP; i++) begin
      below = 0;
      not_above = 0;
      for (j = 0; j < SAMPLES_PER_GROUP; j++) begin
        if (pred_group[j] < pred_group[i]) below++;
        if (pred_group[j] <= pred_group[i]) not_above++;
      end
      if (below <= MEDIAN_IDX && not_above > MEDIAN_IDX) pick = pred_group[i];
    end
    return pick;
  endfunction

  task automatic predict_turn(input logic op, input logic signed [9:0] deg,
                              input logic [DEG_W-1:0] brg, output bit counted);
    turn_report_t     rpt;
    logic [DEG_W-1:0] b;
    int               med;
    int               diff;
    int               arc;
    counted = 1'b1;
    rpt = '0;
    if (op == OP_START) begin
      pred_count = 0;
      pred_angle = deg;
      if (deg == 0) begin
        pred_phase = TURN_IDLE;
        rpt.kind = KIND_DONE;
        expected_reports.push_back(rpt);
        done_count++;
      end else begin
        pred_phase = TURN_AWAIT_FIRST;
      end
      return;
    end
    if (pred_phase == TURN_IDLE) begin
      counted = 1'b0;
      return;
    end
    b = (brg >= FULL_CIRCLE) ? brg - FULL_CIRCLE : brg;
    pred_group[pred_count] = b;
    pred_count++;
    if (pred_count < SAMPLES_PER_GROUP) return;
    pred_count = 0;
    med = group_lower_median();
    rpt.positive = (pred_angle > 0);
    rpt.median = DEG_W'(med);
    if (pred_phase == TURN_AWAIT_FIRST) begin
      pred_target = DEG_W'(wrap_degrees(med + pred_angle));
      pred_phase = TURN_ACTIVE;
      rpt.kind = KIND_DRIVE;
      rpt.power = pred_power;
      drive_count++;
    end else begin
      diff = med - int'(pred_target);
      if (diff < 0) diff = -diff;
      arc = (diff > 360 - diff) ? 360 - diff : diff;
      if (arc < int'(pred_tolerance)) begin
        pred_phase = TURN_IDLE;
        rpt.kind = KIND_DONE;
        done_count++;
      end else begin
        rpt.kind = KIND_TURNING;
        turning_count++;
      end
    end
    rpt.target = pred_target;
    expected_reports.push_back(rpt);
  endtask

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    turn_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report kind %0d median %0d",
                                  result_kind, median_bearing));
      end else begin
        want = expected_reports.pop_front();
        check_field("result_kind", result_kind, want.kind);
        check_field("turn_positive", turn_positive, want.positive);
        check_field("power", power, want.power);
        check_field("median_bearing", median_bearing, want.median);
        check_field("target_heading", target_heading, want.target);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ----------------------------------------------------------------- stimulus
  task automatic send_item(input logic op, input logic signed [9:0] deg,
                           input logic [DEG_W-1:0] brg);
    bit counted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    turn_degrees <= deg;
    bearing      <= brg;
    do @(posedge clk); while (!in_ready);
    predict_turn(op, deg, brg, counted);
    if (counted) items_sent++;
    else ignored_count++;
  endtask

  task automatic send_start(input int deg);
    send_item(OP_START, 10'(deg), DEG_W'($urandom_range(511)));
  endtask

  task automatic send_sample(input int brg);
    send_item(OP_SAMPLE, 10'($urandom_range(1023)), DEG_W'(brg));
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TOLERANCE) pred_tolerance = val;
    else pred_power = val[6:0];
  endtask

  function automatic int noisy_bearing(input int center, input int spread);
    int v;
    if ($urandom_range(9) == 0) return $urandom_range(511);
    v = center + int'($urandom_range(2 * spread)) - spread;
    return wrap_degrees(v);
  endfunction

  // one turn: start, a first group around a random heading, then groups that
  // close in on the target; now and then cut short mid-group
  task automatic run_turn(input int n_groups);
    int  center;
    int  spread;
    int  off;
    int  g;
    int  k;
    int  cut_at;
    bit  abandon;
    send_start(int'($urandom_range(718)) - 359);
    spread  = $urandom_range(1, 8);
    abandon = ($urandom_range(7) == 0);
    cut_at  = $urandom_range(SAMPLES_PER_GROUP - 1);
    center  = $urandom_range(359);
    for (g = 0; g < n_groups; g++) begin
      if (pred_phase == TURN_IDLE) return;
      if (g > 0) begin
        off = (n_groups - 1 - g) * 25;
        center = int'(pred_target);
        center = center + int'($urandom_range(2 * off)) - off;
      end
      for (k = 0; k < SAMPLES_PER_GROUP; k++) begin
        if (abandon && g == n_groups - 1 && k == cut_at) return;
        send_sample(noisy_bearing(center, spread));
      end
    end
  endtask

  task automatic run_random_turns(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick == 0) send_start(0);
      else if (pick == 1) repeat ($urandom_range(1, 4)) send_sample($urandom_range(511));
      else run_turn($urandom_range(2, 6));
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    int first_group [SAMPLES_PER_GROUP] = '{0, 359, 511, 360, 100, 200, 300, 50, 150, 250};
    int wrap_group [SAMPLES_PER_GROUP] = '{358, 2, 0, 1, 359, 3, 357, 1, 356, 4};
    int k;
    set_idling(25, 74);
    send_start(0);
    send_sample(200);
    send_start(359);
    for (k = 0; k < SAMPLES_PER_GROUP; k++) send_sample(first_group[k]);
    // new start abandons the turn under way
    send_start(-359);
    for (k = 0; k < SAMPLES_PER_GROUP; k++) send_sample(wrap_group[k]);
    // angles past a full turn, both signs
    send_start(-512);
    for (k = 0; k < SAMPLES_PER_GROUP; k++) send_sample(wrap_group[k]);
    send_start(511);
    for (k = 0; k < SAMPLES_PER_GROUP; k++) send_sample(wrap_group[k] + 250);
    drain_block();
  endtask

  task automatic test_tolerance_extremes();
    set_idling(25, 74);
    write_reg(CFG_TOLERANCE, 8'd0);
    write_reg(CFG_POWER, 8'd0);
    run_random_turns(150);
    drain_block();
    write_reg(CFG_TOLERANCE, 8'd179);
    write_reg(CFG_POWER, 8'd100);
    run_random_turns(150);
    drain_block();
  endtask

  task automatic test_busy_receiver();
    set_idling(25, 74);
    write_reg(CFG_TOLERANCE, 8'($urandom_range(5, 40)));
    write_reg(CFG_POWER, 8'($urandom_range(100)));
    run_random_turns(380);
    drain_block();
  endtask

  task automatic test_sparse_sender();
    set_idling(74, 25);
    write_reg(CFG_TOLERANCE, 8'($urandom_range(5, 40)));
    write_reg(CFG_POWER, 8'($urandom_range(100)));
    run_random_turns(380);
    drain_block();
  endtask

  task automatic test_full_rate_backpressure();
    set_idling(0, 0);
    write_reg(CFG_TOLERANCE, 8'($urandom_range(5, 40)));
    write_reg(CFG_POWER, 8'($urandom_range(100)));
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    run_random_turns(380);
    drain_block();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_START;
    turn_degrees = '0;
    bearing      = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_TOLERANCE;
    cfg_data     = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_TOLERANCE, 8'd20);
    write_reg(CFG_POWER, 8'd100);
    test_directed();
    test_tolerance_extremes();
    test_busy_receiver();
    test_sparse_sender();
    test_full_rate_backpressure();

    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    $display("Sent %0d transactions (%0d stray samples ignored): %0d drive, %0d turning, %0d done",
             items_sent, ignored_count, drive_count, turning_count, done_count);
    $display("Tolerance 0 to 179, power 0 to 100, three idling mixes and a long receiver hold-off");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
